FILE: hdl/mlt_pkg.sv
// Shared types and constants for the min line tree.
package mlt_pkg;

  // Default domain: positions 0 .. 2^16-1
  localparam int DOMAIN_BITS_DEF = 16;

  // Field widths
  localparam int SLOPE_W = 32;
  localparam int ICPT_W  = 48;
  localparam int QX_W    = 16;
  localparam int VAL_W   = 64;

  // Stored entry: {valid, slope, intercept}
  localparam int ENTRY_W = 1 + SLOPE_W + ICPT_W;

  // Answer for a path that holds no line
  localparam logic [VAL_W-1:0] EMPTY_VALUE = 64'h4000_0000_0000_0000;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_e;

  // Request as it travels down the row of level cells
  typedef struct packed {
    logic               live;   // insert still walking
    cmd_e               cmd;
    logic [SLOPE_W-1:0] slope;  // line being carried down
    logic [ICPT_W-1:0]  icpt;
    logic [QX_W-1:0]    qx;
    logic [VAL_W-1:0]   best;   // running minimum of a query
    logic               found;
  } mlt_tok_t;

endpackage

FILE: hdl/mlt_req_if.sv
// Request channel: command, line and query position.
interface mlt_req_if;
  import mlt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic signed [SLOPE_W-1:0] line_slope;
  logic signed [ICPT_W-1:0]  line_intercept;
  logic [QX_W-1:0]           query_x;

  modport source (output valid, output cmd, output line_slope, output line_intercept,
                  output query_x, input ready);
  modport sink   (input valid, input cmd, input line_slope, input line_intercept,
                  input query_x, output ready);
endinterface

FILE: hdl/mlt_rsp_if.sv
// Response channel: query minimum and empty flag.
interface mlt_rsp_if;
  import mlt_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] min_value;
  logic                    no_line;

  modport source (output valid, output min_value, output no_line, input ready);
  modport sink   (input valid, input min_value, input no_line, output ready);
endinterface

FILE: hdl/mlt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/mlt_cell.sv
// One tree level: node memory, line evaluator and insert/query decision.
module mlt_cell #(
  parameter int DOMAIN_BITS = mlt_pkg::DOMAIN_BITS_DEF,
  parameter int LEVEL       = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   tok_valid_i,
  input  mlt_pkg::mlt_tok_t      tok_i,
  input  logic [DOMAIN_BITS-1:0] path_i,
  input  logic                   clr_en_i,
  input  logic [DOMAIN_BITS-1:0] clr_addr_i,
  output logic                   tok_valid_o,
  output mlt_pkg::mlt_tok_t      tok_o,
  output logic [DOMAIN_BITS-1:0] path_o
);
  import mlt_pkg::*;

  localparam int DEPTH   = 1 << LEVEL;
  localparam int AW      = (LEVEL == 0) ? 1 : LEVEL;
  localparam int SPAN_SH = DOMAIN_BITS - LEVEL;
  localparam bit IS_LEAF = (LEVEL == DOMAIN_BITS);
  localparam int HALF_SH = IS_LEAF ? 0 : DOMAIN_BITS - LEVEL - 1;
  localparam logic [DOMAIN_BITS-1:0] HALF_MASK =
      IS_LEAF ? '0 : DOMAIN_BITS'((64'd1 << HALF_SH) - 64'd1);
  localparam int XW      = (DOMAIN_BITS > QX_W) ? DOMAIN_BITS : QX_W;
  localparam int OPA_W   = SLOPE_W + 1;
  localparam int PROD_W  = OPA_W + XW + 1;

  // Stage 1: read issued, request captured
  logic                   s1_valid_q;
  mlt_tok_t               s1_tok_q;
  logic [DOMAIN_BITS-1:0] s1_path_q;

  // Stage 2: product registered
  logic                   s2_valid_q;
  mlt_tok_t               s2_tok_q;
  logic [DOMAIN_BITS-1:0] s2_path_q;
  logic                   s2_old_valid_q;
  logic [SLOPE_W-1:0]     s2_old_slope_q;
  logic [ICPT_W-1:0]      s2_old_icpt_q;
  logic [VAL_W-1:0]       s2_prod_q;
  logic [VAL_W-1:0]       s2_addend_q;
  logic                   s2_slope_gt_q;
  logic                   s2_qdir_q;

  // Hand-off to the next level
  logic                   out_valid_q;
  mlt_tok_t               out_tok_q;
  logic [DOMAIN_BITS-1:0] out_path_q;

  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          wr_addr;
  logic                   ram_we;
  logic [ENTRY_W-1:0]     ram_wdata;
  logic [ENTRY_W-1:0]     rd_data;

  logic                   old_valid;
  logic [SLOPE_W-1:0]     old_slope;
  logic [ICPT_W-1:0]      old_icpt;
  logic [DOMAIN_BITS-1:0] mid;
  logic signed [OPA_W-1:0]  d_slope;
  logic signed [ICPT_W:0]   d_icpt;
  logic signed [OPA_W-1:0]  op_a;
  logic [XW-1:0]            x_val;
  logic signed [XW:0]       op_b;
  logic signed [PROD_W-1:0] prod;
  logic [VAL_W-1:0]         addend;
  logic                     slope_gt;
  logic                     qdir;

  logic [VAL_W-1:0]       sum;
  logic                   sum_neg;
  logic                   sum_pos;
  logic                   keep_new;
  logic                   wr_new;
  logic                   dir;
  mlt_tok_t               nxt_tok;

  // Node memory of this level
  assign rd_addr = (LEVEL == 0) ? '0 : path_i[AW-1:0];
  assign wr_addr = clr_en_i ? ((LEVEL == 0) ? '0 : clr_addr_i[AW-1:0])
                            : ((LEVEL == 0) ? '0 : s2_path_q[AW-1:0]);
  assign ram_we    = clr_en_i || (s2_valid_q && wr_new);
  assign ram_wdata = clr_en_i ? '0 : {1'b1, s2_tok_q.slope, s2_tok_q.icpt};

  mlt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign old_valid = rd_data[ENTRY_W-1];
  assign old_slope = rd_data[ICPT_W +: SLOPE_W];
  assign old_icpt  = rd_data[ICPT_W-1:0];

  // Stage 1: insert evaluates new minus old at the midpoint, query evaluates old at x
  always_comb begin
    mid      = (s1_path_q << SPAN_SH) | HALF_MASK;
    d_slope  = $signed({s1_tok_q.slope[SLOPE_W-1], s1_tok_q.slope})
             - $signed({old_slope[SLOPE_W-1], old_slope});
    d_icpt   = $signed({s1_tok_q.icpt[ICPT_W-1], s1_tok_q.icpt})
             - $signed({old_icpt[ICPT_W-1], old_icpt});
    slope_gt = $signed(s1_tok_q.slope) > $signed(old_slope);
    qdir     = XW'(s1_tok_q.qx) > XW'(mid);
    if (s1_tok_q.cmd == CMD_INSERT) begin
      op_a   = d_slope;
      x_val  = XW'(mid);
      addend = {{(VAL_W-ICPT_W-1){d_icpt[ICPT_W]}}, d_icpt};
    end else begin
      op_a   = $signed({old_slope[SLOPE_W-1], old_slope});
      x_val  = XW'(s1_tok_q.qx);
      addend = {{(VAL_W-ICPT_W){old_icpt[ICPT_W-1]}}, old_icpt};
    end
    op_b = $signed({1'b0, x_val});
    prod = op_a * op_b;
  end

  // Stage 2: finish the sum and decide what stays and what moves on
  assign sum     = s2_prod_q + s2_addend_q;
  assign sum_neg = sum[VAL_W-1];
  assign sum_pos = !sum[VAL_W-1] && (sum != '0);

  always_comb begin
    nxt_tok  = s2_tok_q;
    dir      = s2_qdir_q;
    wr_new   = 1'b0;
    keep_new = 1'b0;
    if (s2_tok_q.live) begin
      if (s2_tok_q.cmd == CMD_INSERT) begin
        if (!s2_old_valid_q) begin
          // empty node takes the line
          wr_new       = 1'b1;
          nxt_tok.live = 1'b0;
        end else if (IS_LEAF) begin
          // old line stays only if strictly lower
          wr_new       = !sum_pos;
          nxt_tok.live = 1'b0;
        end else begin
          keep_new = s2_slope_gt_q ? !sum_pos : sum_neg;
          dir      = s2_slope_gt_q ? !sum_pos : !sum_neg;
          wr_new   = keep_new;
          if (keep_new) begin
            nxt_tok.slope = s2_old_slope_q;
            nxt_tok.icpt  = s2_old_icpt_q;
          end
        end
      end else if (s2_old_valid_q &&
                   (!s2_tok_q.found || ($signed(sum) < $signed(s2_tok_q.best)))) begin
        nxt_tok.best  = sum;
        nxt_tok.found = 1'b1;
      end
    end
  end

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= tok_valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    s1_tok_q       <= tok_i;
    s1_path_q      <= path_i;
    s2_tok_q       <= s1_tok_q;
    s2_path_q      <= s1_path_q;
    s2_old_valid_q <= old_valid;
    s2_old_slope_q <= old_slope;
    s2_old_icpt_q  <= old_icpt;
    s2_prod_q      <= {{(VAL_W-PROD_W){prod[PROD_W-1]}}, prod};
    s2_addend_q    <= addend;
    s2_slope_gt_q  <= slope_gt;
    s2_qdir_q      <= qdir;
    out_tok_q      <= nxt_tok;
    out_path_q     <= {s2_path_q[DOMAIN_BITS-2:0], dir};
  end

  assign tok_valid_o = out_valid_q;
  assign tok_o       = out_tok_q;
  assign path_o      = out_path_q;

endmodule

FILE: hdl/min_line_tree_insert_query.sv
// Min line tree top level: one cell per tree level.
// Only one request is in flight: a new one is taken after the last has left the row.
// A request is taken while an earlier result still waits at the output.
// After reset a clearing pass empties every node; no request is taken until it ends.
module min_line_tree_insert_query #(
  parameter int DOMAIN_BITS = mlt_pkg::DOMAIN_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mlt_req_if.sink     req_i,
  mlt_rsp_if.source   rsp_o
);
  import mlt_pkg::*;

  localparam int NCELL = DOMAIN_BITS + 1;

  state_e                 state_q, state_d;
  logic [DOMAIN_BITS-1:0] clr_cnt_q, clr_cnt_d;
  logic                   clr_last;

  logic                   tok_valid  [NCELL+1];
  mlt_tok_t               tok_chain  [NCELL+1];
  logic [DOMAIN_BITS-1:0] path_chain [NCELL+1];

  logic                   accept;
  logic                   in_ready;
  logic                   clr_en;
  logic                   done;
  logic                   done_query;
  logic                   out_free;
  logic                   load_out_chain;
  logic                   load_hold;
  logic                   load_out_hold;

  logic                   out_valid_q, out_valid_d;
  logic [VAL_W-1:0]       out_value_q;
  logic                   out_no_line_q;
  logic [VAL_W-1:0]       hold_value_q;
  logic                   hold_no_line_q;

  assign accept     = req_i.valid && in_ready;
  assign clr_last   = &clr_cnt_q;
  assign done       = tok_valid[NCELL];
  assign done_query = done && (tok_chain[NCELL].cmd == CMD_QUERY);
  assign out_free   = !out_valid_q || rsp_o.ready;

  // Request enters the root cell
  assign tok_valid[0]  = accept;
  assign tok_chain[0]  = '{live:  1'b1,
                           cmd:   cmd_e'(req_i.cmd),
                           slope: req_i.line_slope,
                           icpt:  req_i.line_intercept,
                           qx:    req_i.query_x,
                           best:  EMPTY_VALUE,
                           found: 1'b0};
  assign path_chain[0] = '0;

  // Row of level cells
  for (genvar g = 0; g < NCELL; g++) begin : g_level
    mlt_cell #(
      .DOMAIN_BITS (DOMAIN_BITS),
      .LEVEL       (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tok_valid_i (tok_valid[g]),
      .tok_i       (tok_chain[g]),
      .path_i      (path_chain[g]),
      .clr_en_i    (clr_en),
      .clr_addr_i  (clr_cnt_q),
      .tok_valid_o (tok_valid[g+1]),
      .tok_o       (tok_chain[g+1]),
      .path_o      (path_chain[g+1])
    );
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_last) state_d = ST_IDLE;
      ST_IDLE:  if (accept) state_d = ST_RUN;
      ST_RUN: begin
        if (done) begin
          state_d = (done_query && !out_free) ? ST_HOLD : ST_IDLE;
        end
      end
      ST_HOLD:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready       = 1'b0;
    clr_en         = 1'b0;
    load_out_chain = 1'b0;
    load_hold      = 1'b0;
    load_out_hold  = 1'b0;
    case (state_q)
      ST_CLEAR: clr_en = 1'b1;
      ST_IDLE:  in_ready = 1'b1;
      ST_RUN: begin
        load_out_chain = done_query && out_free;
        load_hold      = done_query && !out_free;
      end
      ST_HOLD:  load_out_hold = out_free;
      default:  clr_en = 1'b0;
    endcase
  end

  assign clr_cnt_d   = clr_en ? clr_cnt_q + 1'b1 : clr_cnt_q;
  assign out_valid_d = (load_out_chain || load_out_hold) ? 1'b1
                     : (rsp_o.ready ? 1'b0 : out_valid_q);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result and parked result
  always_ff @(posedge clk_i) begin
    if (load_out_chain) begin
      out_value_q   <= tok_chain[NCELL].best;
      out_no_line_q <= !tok_chain[NCELL].found;
    end else if (load_out_hold) begin
      out_value_q   <= hold_value_q;
      out_no_line_q <= hold_no_line_q;
    end
    if (load_hold) begin
      hold_value_q   <= tok_chain[NCELL].best;
      hold_no_line_q <= !tok_chain[NCELL].found;
    end
  end

  assign req_i.ready     = in_ready;
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.min_value = out_value_q;
  assign rsp_o.no_line   = out_no_line_q;

  // No request is taken while the nodes are being cleared
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !req_i.ready)
    else $error("request accepted during clearing pass");

  // A request leaves the row only while one is in flight
  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid[NCELL] |-> state_q == ST_RUN)
    else $error("request left the row outside of a run");

  // An accepted request starts a run
  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_RUN)
    else $error("accepted request did not start a run");

  // A parked result only exists behind a stalled output
  a_hold_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_HOLD |-> out_valid_q)
    else $error("result parked while output register empty");

endmodule
